### hw/rtl/rabs_pkg.sv
// Shared types, codes and default sizes for the rotated array search block.
package rabs_pkg;

    // Default store depth and element width.
    localparam int RABS_DEPTH       = 1024;
    localparam int RABS_VALUE_WIDTH = 32;

    // Fixed port widths.
    localparam int RABS_IN_WIDTH     = 32;
    localparam int RABS_ACTION_WIDTH = 2;
    localparam int RABS_POS_WIDTH    = 10;

    // Transaction action codes.
    typedef enum logic [RABS_ACTION_WIDTH-1:0] {
        ACT_CLEAR  = 2'd0,
        ACT_APPEND = 2'd1,
        ACT_SEARCH = 2'd2
    } t_action;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PROBE,
        ST_EVAL,
        ST_WRAP
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear;
        logic append;
        logic init;
        logic probe;
        logic rd_hi;
        logic step_left;
        logic step_right;
        logic report_hit;
        logic report_miss;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic win_open;
        logic hit;
        logic sorted_low;
        logic low_pick;
        logic high_pick;
    } t_dp_status;

endpackage

### hw/rtl/rabs_ctrl.sv
// Controller state machine that sequences clear, append and search transactions.
module rabs_ctrl (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  start,
    input  logic [rabs_pkg::RABS_ACTION_WIDTH-1:0] i_action,
    input  rabs_pkg::t_dp_status                  i_status,
    output rabs_pkg::t_dp_cmd                     o_cmd,
    output logic                                  o_busy
);

    rabs_pkg::t_state r_state;
    rabs_pkg::t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rabs_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and datapath commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            rabs_pkg::ST_IDLE: begin
                if (start) begin
                    case (i_action)
                        rabs_pkg::ACT_CLEAR: begin
                            o_cmd.clear = 1'b1;
                        end
                        rabs_pkg::ACT_APPEND: begin
                            o_cmd.append = 1'b1;
                        end
                        rabs_pkg::ACT_SEARCH: begin
                            o_cmd.init = 1'b1;
                            n_state    = rabs_pkg::ST_PROBE;
                        end
                        default: begin
                            // Unknown action codes are dropped.
                        end
                    endcase
                end
            end
            rabs_pkg::ST_PROBE: begin
                // An empty window ends the search without a hit.
                if (!i_status.win_open) begin
                    o_cmd.report_miss = 1'b1;
                    n_state           = rabs_pkg::ST_IDLE;
                end else begin
                    o_cmd.probe = 1'b1;
                    n_state     = rabs_pkg::ST_EVAL;
                end
            end
            rabs_pkg::ST_EVAL: begin
                if (i_status.hit) begin
                    o_cmd.report_hit = 1'b1;
                    n_state          = rabs_pkg::ST_IDLE;
                end else if (i_status.sorted_low) begin
                    // Lower half is sorted, so it decides directly.
                    if (i_status.low_pick) begin
                        o_cmd.step_left = 1'b1;
                    end else begin
                        o_cmd.step_right = 1'b1;
                    end
                    n_state = rabs_pkg::ST_PROBE;
                end else begin
                    // Upper half is sorted; its last element is needed.
                    o_cmd.rd_hi = 1'b1;
                    n_state     = rabs_pkg::ST_WRAP;
                end
            end
            rabs_pkg::ST_WRAP: begin
                if (i_status.high_pick) begin
                    o_cmd.step_right = 1'b1;
                end else begin
                    o_cmd.step_left = 1'b1;
                end
                n_state = rabs_pkg::ST_PROBE;
            end
            default: begin
                n_state = rabs_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != rabs_pkg::ST_IDLE);

endmodule

### hw/rtl/rabs_datapath.sv
// Datapath with the element store, search window registers and result registers.
module rabs_datapath #(
    parameter int DEPTH       = rabs_pkg::RABS_DEPTH,
    parameter int VALUE_WIDTH = rabs_pkg::RABS_VALUE_WIDTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [rabs_pkg::RABS_IN_WIDTH-1:0]  i_value,
    input  rabs_pkg::t_dp_cmd                   i_cmd,
    output rabs_pkg::t_dp_status                o_status,
    output logic                                o_valid,
    output logic                                o_found,
    output logic [rabs_pkg::RABS_POS_WIDTH-1:0] o_position
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    // Element store with one write port and two registered read ports.
    logic [VALUE_WIDTH-1:0] r_mem [DEPTH];
    logic [VALUE_WIDTH-1:0] r_rd_a;
    logic [VALUE_WIDTH-1:0] r_rd_b;
    logic [AW-1:0]          addr_a;
    logic [AW-1:0]          addr_b;

    logic [CW-1:0]          r_count;
    logic signed [CW:0]     r_lo;
    logic signed [CW:0]     r_hi;
    logic [AW-1:0]          r_mid;
    logic [VALUE_WIDTH-1:0] r_target;
    logic                   r_valid;
    logic                   r_found;
    logic [rabs_pkg::RABS_POS_WIDTH-1:0] r_position;

    logic [63:0]            value_ext;
    logic [VALUE_WIDTH-1:0] value_w;
    logic signed [CW:0]     win_diff;
    logic signed [CW:0]     mid_calc;
    logic signed [VALUE_WIDTH-1:0] t_val;
    logic signed [VALUE_WIDTH-1:0] m_val;
    logic signed [VALUE_WIDTH-1:0] s_val;
    logic signed [VALUE_WIDTH-1:0] e_val;
    logic [31:0]            mid_ext;

    // Input value is sign-extended, then held at the element width.
    assign value_ext = {{32{i_value[rabs_pkg::RABS_IN_WIDTH-1]}}, i_value};
    assign value_w   = value_ext[VALUE_WIDTH-1:0];

    // Midpoint of the current window.
    assign win_diff = r_hi - r_lo;
    assign mid_calc = r_lo + (win_diff >>> 1);

    // Port A reads the midpoint; port B reads the low end, or the high end on request.
    assign addr_a = i_cmd.probe ? mid_calc[AW-1:0] : r_mid;
    assign addr_b = i_cmd.rd_hi ? r_hi[AW-1:0]
                  : (i_cmd.probe ? r_lo[AW-1:0] : r_mid);

    always_ff @(posedge i_clk) begin
        if (i_cmd.append && (r_count < CW'(DEPTH))) begin
            r_mem[r_count[AW-1:0]] <= value_w;
        end
        r_rd_a <= r_mem[addr_a];
        r_rd_b <= r_mem[addr_b];
    end

    // Element count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.clear) begin
            r_count <= '0;
        end else if (i_cmd.append && (r_count < CW'(DEPTH))) begin
            r_count <= r_count + 1'b1;
        end
    end

    // Search window and target.
    always_ff @(posedge i_clk) begin
        if (i_cmd.init) begin
            r_lo     <= '0;
            r_hi     <= $signed({1'b0, r_count}) - (CW + 1)'(1);
            r_target <= value_w;
        end else begin
            if (i_cmd.step_left) begin
                r_hi <= $signed((CW + 1)'(r_mid)) - (CW + 1)'(1);
            end
            if (i_cmd.step_right) begin
                r_lo <= $signed((CW + 1)'(r_mid)) + (CW + 1)'(1);
            end
        end
        if (i_cmd.probe) begin
            r_mid <= mid_calc[AW-1:0];
        end
    end

    // Probe comparisons on the registered read data.
    assign t_val = $signed(r_target);
    assign m_val = $signed(r_rd_a);
    assign s_val = $signed(r_rd_b);
    assign e_val = $signed(r_rd_b);

    always_comb begin
        o_status            = '0;
        o_status.win_open   = (r_lo <= r_hi);
        o_status.hit        = (t_val == m_val);
        o_status.sorted_low = (s_val <= m_val);
        o_status.low_pick   = (s_val <= t_val) && (t_val < m_val);
        o_status.high_pick  = (t_val <= e_val) && (t_val > m_val);
    end

    // Result registers; the strobe lasts one cycle.
    assign mid_ext = 32'(r_mid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.report_hit | i_cmd.report_miss;
        end
        r_found    <= i_cmd.report_hit;
        r_position <= i_cmd.report_hit ? mid_ext[rabs_pkg::RABS_POS_WIDTH-1:0] : '0;
    end

    assign o_valid    = r_valid;
    assign o_found    = r_found;
    assign o_position = r_position;

endmodule

### hw/rtl/rotated_array_binary_search.sv
// Top level of the rotated sorted array search block.
//
// Usage: a transaction is taken at a rising edge with start high and busy
// low. A clear transaction empties the store and an append transaction writes
// the next element; both finish in the cycle they are taken and leave busy
// low, and appends past the store depth are dropped. A search transaction
// raises busy and runs a binary search that honors the rotation point.
// Each probe passes through the PROBE and EVAL states when it hits or the
// lower half of the window is sorted, and also through WRAP when the last
// element of the window must be read as well, since the store has two read
// ports with registered data. A search of a store with N elements makes at
// most floor(log2(N)) + 1 probes, and a miss ends in a further PROBE state
// that sees the empty window; an empty store ends in its first PROBE state.
// The result appears on o_found and o_position for exactly one cycle,
// marked by o_valid, in the same cycle that busy falls; the receiver cannot
// stall it. A miss or an empty store gives o_found low and o_position zero.
// Reset empties the store and returns the controller to idle; store
// contents are not cleared.
module rotated_array_binary_search #(
    parameter int DEPTH       = rabs_pkg::RABS_DEPTH,
    parameter int VALUE_WIDTH = rabs_pkg::RABS_VALUE_WIDTH
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic [rabs_pkg::RABS_ACTION_WIDTH-1:0] i_action,
    input  logic [rabs_pkg::RABS_IN_WIDTH-1:0]     i_value,
    output logic                                   o_valid,
    output logic                                   o_found,
    output logic [rabs_pkg::RABS_POS_WIDTH-1:0]    o_position
);

    rabs_pkg::t_dp_cmd    dp_cmd;
    rabs_pkg::t_dp_status dp_status;

    // Sequencing of transactions and probes.
    rabs_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_action (i_action),
        .i_status (dp_status),
        .o_cmd    (dp_cmd),
        .o_busy   (busy)
    );

    // Store, window and result registers.
    rabs_datapath #(
        .DEPTH       (DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_value    (i_value),
        .i_cmd      (dp_cmd),
        .o_status   (dp_status),
        .o_valid    (o_valid),
        .o_found    (o_found),
        .o_position (o_position)
    );

`ifndef SYNTH
    // A result only follows a search that held busy.
    a_valid_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result strobe without a search in progress");

    // Clear and append transactions produce no result.
    a_no_result_for_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_action != rabs_pkg::ACT_SEARCH)) |=> !o_valid)
        else $error("result strobe after a non-search transaction");

    // The window never narrows from both sides at once.
    a_single_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(dp_cmd.step_left && dp_cmd.step_right))
        else $error("both window bounds updated in one cycle");

    // A miss reports position zero.
    a_miss_position: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_found) |-> (o_position == '0))
        else $error("miss reported with a nonzero position");
`endif

endmodule
